// ===== design/hgv_pkg.sv =====
package hgv_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned DiffW = 33;
  localparam int unsigned MagW  = 32;
  localparam int unsigned SpdW  = 31;
  localparam int unsigned TrigW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned NumW  = 48;

  localparam logic [2:0] RegTargetX   = 3'd0;
  localparam logic [2:0] RegTargetY   = 3'd1;
  localparam logic [2:0] RegTargetHdg = 3'd2;
  localparam logic [2:0] RegTransSpd  = 3'd3;
  localparam logic [2:0] RegRotSpd    = 3'd4;
  localparam logic [2:0] RegRotCos    = 3'd5;
  localparam logic [2:0] RegRotSin    = 3'd6;
  localparam logic [2:0] RegStopTime  = 3'd7;

  // One restoring-division step: remainder is one bit wider than the divisor.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [MagW:0]   rem;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [MagW-1:0] den);
    logic [MagW+1:0] sh;
    logic [MagW+1:0] df;
    div_state_t      r;
    sh = {s.rem, s.num[NumW-1]};
    df = sh - {2'b00, den};
    r.num = {s.num[NumW-2:0], ~df[MagW+1]};
    r.rem = df[MagW+1] ? sh[MagW:0] : df[MagW:0];
    return r;
  endfunction

endpackage

// ===== design/hgv_div.sv =====
// Pipelined unsigned divider, num (48 bit) / den (32 bit), four bits per stage.
module hgv_div
  import hgv_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [NumW-1:0]     num,
  input  logic [MagW-1:0]     den,
  output logic [NumW-1:0]     quot
);

  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned Stages = NumW / BitsPerStage;

  div_state_t      st  [Stages+1];
  logic [MagW-1:0] dn  [Stages+1];

  assign st[0].num = num;
  assign st[0].rem = '0;
  assign dn[0]     = den;

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    div_state_t c;
    always_comb begin
      c = st[g];
      for (int b = 0; b < BitsPerStage; b++) begin
        c = div_step(c, dn[g]);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[g+1] <= c;
        dn[g+1] <= dn[g];
      end
    end
  end

  assign quot = st[Stages].num;

endmodule

// ===== design/hgv_rot.sv =====
// Body-frame rotation: one multiply stage, one sum stage, round and saturate.
module hgv_rot
  import hgv_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [PosW-1:0]   vwx,
  input  logic signed [PosW-1:0]   vwy,
  input  logic signed [TrigW-1:0]  c,
  input  logic signed [TrigW-1:0]  s,
  output logic signed [PosW-1:0]   vx,
  output logic signed [PosW-1:0]   vy
);

  localparam int unsigned PW = PosW + TrigW;
  localparam int unsigned SW = PW + 1;

  logic signed [PW-1:0] xc, ys, yc, xs;
  logic signed [SW-1:0] sum_x, sum_y;

  function automatic logic signed [PosW-1:0] rnd(logic signed [SW-1:0] v);
    logic signed [SW:0]      b;
    logic signed [SW-14:0]   r;
    b = {v[SW-1], v} + (SW+1)'(8192);
    r = b[SW:14];
    if (r > (SW-13)'(32'sh7fffffff)) return 32'sh7fffffff;
    else if (r < -(SW-13)'(64'sh80000000)) return 32'sh80000000;
    else return r[PosW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      xc <= vwx * c;
      ys <= vwy * s;
      yc <= vwy * c;
      xs <= vwx * s;
      sum_x <= {xc[PW-1], xc} + {ys[PW-1], ys};
      sum_y <= {yc[PW-1], yc} - {xs[PW-1], xs};
      vx <= rnd(sum_x);
      vy <= rnd(sum_y);
    end
  end

endmodule

// ===== design/holonomic_goto_velocity.sv =====
// Pipeline steps in order: differences, time divide, maximum, velocity divide,
// rotate, output register.
// Throughput: one transaction per cycle; the pipeline advances when the output
// register is free or taken.
// Reset: synchronous rst clears valid bits and loads register reset values.
module holonomic_goto_velocity
  import hgv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [PosW-1:0]  pose_x,
  input  logic signed [PosW-1:0]  pose_y,
  input  logic signed [PosW-1:0]  pose_heading,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PosW-1:0]  drive_vx,
  output logic signed [PosW-1:0]  drive_vy,
  output logic signed [PosW-1:0]  drive_turn,
  output logic [TimeW-1:0]        remaining_time,
  output logic                    arrived
);

  localparam int unsigned DivLat = NumW / 4;
  localparam int unsigned Lat = 1 + DivLat + 1 + DivLat + 3;

  logic signed [PosW-1:0]  target_x, target_y, target_heading;
  logic [SpdW-1:0]         max_trans_speed, max_rot_speed, stop_time;
  logic signed [TrigW-1:0] rot_cos, rot_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      target_heading <= '0;
      max_trans_speed <= SpdW'(6554);
      max_rot_speed <= SpdW'(6554);
      rot_cos <= TrigW'(16384);
      rot_sin <= '0;
      stop_time <= SpdW'(655);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTargetX:   target_x <= cfg_data;
        RegTargetY:   target_y <= cfg_data;
        RegTargetHdg: target_heading <= cfg_data;
        RegTransSpd:  max_trans_speed <= cfg_data[SpdW-1:0];
        RegRotSpd:    max_rot_speed <= cfg_data[SpdW-1:0];
        RegRotCos:    rot_cos <= cfg_data[TrigW-1:0];
        RegRotSin:    rot_sin <= cfg_data[TrigW-1:0];
        RegStopTime:  stop_time <= cfg_data[SpdW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid shift
  logic en;
  logic [Lat-1:0] vld;
  logic           res_valid;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end

  // Stage 1: differences
  logic signed [DiffW-1:0] dx, dy, dh;
  logic [SpdW-1:0] ts_e, rs_e;
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {target_x[PosW-1], target_x} - {pose_x[PosW-1], pose_x};
      dy <= {target_y[PosW-1], target_y} - {pose_y[PosW-1], pose_y};
      dh <= {target_heading[PosW-1], target_heading}
            - {pose_heading[PosW-1], pose_heading};
      ts_e <= (max_trans_speed == '0) ? SpdW'(1) : max_trans_speed;
      rs_e <= (max_rot_speed == '0) ? SpdW'(1) : max_rot_speed;
    end
  end

  function automatic logic [MagW:0] mag(logic signed [DiffW-1:0] d);
    return d[DiffW-1] ? (MagW+1)'(0) - d[MagW:0] : d[MagW:0];
  endfunction

  logic [MagW:0] mx, my, mh;
  assign mx = mag(dx);
  assign my = mag(dy);
  assign mh = mag(dh);

  // Time terms: magnitude < 2^32 so numerator fits 48 bits
  logic [NumW-1:0] qx, qy, qh;
  hgv_div u_tx (.clk, .en, .num({mx[MagW-1:0], 16'h0}), .den({1'b0, ts_e}), .quot(qx));
  hgv_div u_ty (.clk, .en, .num({my[MagW-1:0], 16'h0}), .den({1'b0, ts_e}), .quot(qy));
  hgv_div u_th (.clk, .en, .num({mh[MagW-1:0], 16'h0}), .den({1'b0, rs_e}), .quot(qh));

  // Carry differences alongside the divider
  logic signed [DiffW-1:0] dx_d [DivLat], dy_d [DivLat], dh_d [DivLat];
  always_ff @(posedge clk) begin
    if (en) begin
      dx_d[0] <= dx; dy_d[0] <= dy; dh_d[0] <= dh;
      for (int i = 1; i < DivLat; i++) begin
        dx_d[i] <= dx_d[i-1]; dy_d[i] <= dy_d[i-1]; dh_d[i] <= dh_d[i-1];
      end
    end
  end

  function automatic logic [TimeW-1:0] satt(logic [NumW-1:0] q);
    return (q[NumW-1:TimeW] != '0) ? '1 : q[TimeW-1:0];
  endfunction

  // Stage: maximum time and arrival
  logic [TimeW-1:0] tx, ty, th, tmax, t_r;
  logic             arr_r;
  logic signed [DiffW-1:0] dx_m, dy_m, dh_m;
  always_comb begin
    tx = satt(qx); ty = satt(qy); th = satt(qh);
    tmax = tx;
    if (ty > tmax) tmax = ty;
    if (th > tmax) tmax = th;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= tmax;
      arr_r <= (tmax == '0) || (tmax < {1'b0, stop_time});
      dx_m <= dx_d[DivLat-1]; dy_m <= dy_d[DivLat-1]; dh_m <= dh_d[DivLat-1];
    end
  end

  logic [MagW:0] mvx, mvy, mvh;
  logic [TimeW-1:0] tden;
  assign mvx = mag(dx_m);
  assign mvy = mag(dy_m);
  assign mvh = mag(dh_m);
  assign tden = (t_r == '0) ? TimeW'(1) : t_r;

  logic [NumW-1:0] ux, uy, uh;
  hgv_div u_vx (.clk, .en, .num({mvx[MagW-1:0], 16'h0}), .den(tden), .quot(ux));
  hgv_div u_vy (.clk, .en, .num({mvy[MagW-1:0], 16'h0}), .den(tden), .quot(uy));
  hgv_div u_vh (.clk, .en, .num({mvh[MagW-1:0], 16'h0}), .den(tden), .quot(uh));

  logic [DivLat-1:0] sx_d, sy_d, sh_d, arr_d;
  logic [TimeW-1:0]  t_d [DivLat];
  always_ff @(posedge clk) begin
    if (en) begin
      sx_d <= {sx_d[DivLat-2:0], dx_m[DiffW-1]};
      sy_d <= {sy_d[DivLat-2:0], dy_m[DiffW-1]};
      sh_d <= {sh_d[DivLat-2:0], dh_m[DiffW-1]};
      arr_d <= {arr_d[DivLat-2:0], arr_r};
      t_d[0] <= t_r;
      for (int i = 1; i < DivLat; i++) t_d[i] <= t_d[i-1];
    end
  end

  function automatic logic signed [PosW-1:0] vsat(logic [NumW-1:0] q, logic neg);
    if (q >= NumW'(64'h80000000)) return neg ? 32'sh80000000 : 32'sh7fffffff;
    else return neg ? -$signed(q[PosW-1:0]) : $signed(q[PosW-1:0]);
  endfunction

  logic signed [PosW-1:0] vwx, vwy, turn_c;
  assign vwx = vsat(ux, sx_d[DivLat-1]);
  assign vwy = vsat(uy, sy_d[DivLat-1]);
  // turn is the negated heading rate, so a positive error saturates at -(2^31-1)
  assign turn_c = sh_d[DivLat-1] ? vsat(uh, 1'b0) : -vsat(uh, 1'b0);

  logic signed [PosW-1:0] bvx, bvy;
  hgv_rot u_rot (.clk, .en, .vwx, .vwy, .c(rot_cos), .s(rot_sin), .vx(bvx), .vy(bvy));

  logic signed [PosW-1:0] turn_d [3];
  logic [TimeW-1:0]       t_e [3];
  logic [2:0]             arr_e;
  always_ff @(posedge clk) begin
    if (en) begin
      turn_d[0] <= turn_c; t_e[0] <= t_d[DivLat-1];
      for (int i = 1; i < 3; i++) begin
        turn_d[i] <= turn_d[i-1]; t_e[i] <= t_e[i-1];
      end
      arr_e <= {arr_e[1:0], arr_d[DivLat-1]};
    end
  end

  assign res_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arrived <= arr_e[2];
      remaining_time <= t_e[2];
      drive_vx <= arr_e[2] ? '0 : bvx;
      drive_vy <= arr_e[2] ? '0 : bvy;
      drive_turn <= arr_e[2] ? '0 : turn_d[2];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_vx) && $stable(remaining_time))
    else $error("result changed while stalled");
  a_arr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> drive_vx == '0 && drive_vy == '0 && drive_turn == '0)
    else $error("velocity not zero on arrival");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule
